@@ design/ifts_pkg.sv @@
// Package for the image file type sniffer: payload structs, scanner phase
// enums, size constants and the small classification helper functions.
// No dependencies.
package ifts_pkg;

    localparam int SvgScanBytesDefault   = 4096;
    localparam int PrologueLimitDefault  = 64;
    localparam int AttributeLimitDefault = 4096;

    localparam int PosW    = 13;
    localparam logic [PosW-1:0] PosMax = 13'd8191;
    localparam int HeadN   = 12;
    localparam int TailN   = 18;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0] file_kind;
        logic [3:0] signature_id;
    } t_out_item;

    typedef enum logic [2:0] {
        EXR_HEADER, EXR_NAME, EXR_TYPE, EXR_SIZE, EXR_VALUE, EXR_DONE
    } t_exr_phase;

    typedef enum logic [3:0] {
        SV_BOM0, SV_BOM1, SV_BOM2, SV_SPACE, SV_LT, SV_BANG, SV_BANGDASH,
        SV_DOCKEY, SV_PI, SV_COMMENT, SV_DOCTYPE, SV_NAME
    } t_svg_phase;

    localparam logic [1:0] VERDICT_PENDING = 2'd0;
    localparam logic [1:0] VERDICT_YES     = 2'd1;
    localparam logic [1:0] VERDICT_NO      = 2'd2;

    localparam logic [1:0] KIND_UNKNOWN = 2'd0;
    localparam logic [1:0] KIND_PAINT   = 2'd1;
    localparam logic [1:0] KIND_RASTER  = 2'd2;
    localparam logic [1:0] KIND_VECTOR  = 2'd3;

    localparam logic [3:0] SIG_NONE = 4'd0,  SIG_EXR = 4'd1,  SIG_PNG = 4'd2;
    localparam logic [3:0] SIG_PSD = 4'd3,   SIG_HDR = 4'd4,  SIG_DPX = 4'd5;
    localparam logic [3:0] SIG_CIN = 4'd6,   SIG_GIF = 4'd7,  SIG_WEBP = 4'd8;
    localparam logic [3:0] SIG_TIFF = 4'd9,  SIG_JPEG = 4'd10, SIG_BMP = 4'd11;
    localparam logic [3:0] SIG_PNM = 4'd12,  SIG_TGA = 4'd13, SIG_SVG = 4'd14;

    localparam logic [4:0] MarkerMismatch = 5'd31;
    localparam logic [4:0] MarkerLen      = 5'd10;

    function automatic logic [7:0] marker_char(input logic [4:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0: c = "n";
            5'd1: c = "p";
            5'd2: c = ":";
            5'd3: c = "v";
            5'd4: c = "e";
            5'd5: c = "r";
            5'd6: c = "s";
            5'd7: c = "i";
            5'd8: c = "o";
            5'd9: c = "n";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] doctype_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd3: c = "O";
            4'd4: c = "C";
            4'd5: c = "T";
            4'd6: c = "Y";
            4'd7: c = "P";
            4'd8: c = "E";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] tga_foot_char(input int idx);
        logic [7:0] c;
        case (idx)
            0: c = "T";   1: c = "R";   2: c = "U";   3: c = "E";
            4: c = "V";   5: c = "I";   6: c = "S";   7: c = "I";
            8: c = "O";   9: c = "N";   10: c = "-";  11: c = "X";
            12: c = "F";  13: c = "I";  14: c = "L";  15: c = "E";
            16: c = ".";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A);
    endfunction

    function automatic logic is_name_char(input logic [7:0] b);
        return (b inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]}) ||
               (b == 8'h2D) || (b == 8'h5F) || (b == 8'h2E) || (b == 8'h3A);
    endfunction

    function automatic logic name_is_svg(input logic [31:0] tail, input logic [2:0] len);
        return (len == 3'd3 && tail == 32'h0073_7667) ||
               (len >= 3'd5 && tail == 32'h3A73_7667);
    endfunction

endpackage

@@ design/ifts_exr_walk.sv @@
// EXR part-0 attribute walker: one byte per cycle when stepped, looks for the marker name.
// Depends on ifts_pkg.
module ifts_exr_walk #(
    parameter int ATTRIBUTE_LIMIT = ifts_pkg::AttributeLimitDefault
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_step,
    input  logic                     i_clear,
    input  logic [7:0]               i_byte,
    input  logic [ifts_pkg::PosW-1:0] i_pos,
    output logic [1:0]               o_verdict
);
    localparam int CntW = $clog2(ATTRIBUTE_LIMIT + 1);

    ifts_pkg::t_exr_phase r_phase, n_phase;
    logic [4:0]      r_prog, n_prog;
    logic [31:0]     r_skip, n_skip;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic [1:0]      r_verdict, n_verdict;

    always_comb begin
        n_phase   = r_phase;
        n_prog    = r_prog;
        n_skip    = r_skip;
        n_cnt     = r_cnt;
        n_verdict = r_verdict;
        if (r_verdict == ifts_pkg::VERDICT_PENDING) begin
            case (r_phase)
                ifts_pkg::EXR_HEADER: begin
                    if (i_pos >= ifts_pkg::PosW'(7)) begin
                        n_phase = ifts_pkg::EXR_NAME;
                        n_prog  = '0;
                    end
                end
                ifts_pkg::EXR_NAME: begin
                    if (i_byte == 8'h00) begin
                        if (r_prog == 5'd0) begin
                            n_verdict = ifts_pkg::VERDICT_NO;
                            n_phase   = ifts_pkg::EXR_DONE;
                        end else if (r_prog == ifts_pkg::MarkerLen) begin
                            n_verdict = ifts_pkg::VERDICT_YES;
                            n_phase   = ifts_pkg::EXR_DONE;
                        end else begin
                            n_phase = ifts_pkg::EXR_TYPE;
                            n_prog  = '0;
                        end
                    end else if (r_prog < ifts_pkg::MarkerLen &&
                                 i_byte == ifts_pkg::marker_char(r_prog)) begin
                        n_prog = r_prog + 5'd1;
                    end else begin
                        n_prog = ifts_pkg::MarkerMismatch;
                    end
                end
                ifts_pkg::EXR_TYPE: begin
                    if (i_byte == 8'h00) begin
                        if (r_prog == 5'd0) begin
                            n_verdict = ifts_pkg::VERDICT_NO;
                            n_phase   = ifts_pkg::EXR_DONE;
                        end else begin
                            n_phase = ifts_pkg::EXR_SIZE;
                            n_prog  = '0;
                            n_skip  = '0;
                        end
                    end else begin
                        n_prog = 5'd1;
                    end
                end
                ifts_pkg::EXR_SIZE: begin
                    case (r_prog[1:0])
                        2'd0: n_skip[7:0]   = r_skip[7:0]   | i_byte;
                        2'd1: n_skip[15:8]  = r_skip[15:8]  | i_byte;
                        2'd2: n_skip[23:16] = r_skip[23:16] | i_byte;
                        default: n_skip[31:24] = r_skip[31:24] | i_byte;
                    endcase
                    n_prog = r_prog + 5'd1;
                    if (r_prog == 5'd3) begin
                        if (n_skip == 32'd0) begin
                            n_cnt = r_cnt + CntW'(1);
                            if (n_cnt >= CntW'(ATTRIBUTE_LIMIT)) begin
                                n_verdict = ifts_pkg::VERDICT_NO;
                                n_phase   = ifts_pkg::EXR_DONE;
                            end else begin
                                n_phase = ifts_pkg::EXR_NAME;
                                n_prog  = '0;
                            end
                        end else begin
                            n_phase = ifts_pkg::EXR_VALUE;
                        end
                    end
                end
                ifts_pkg::EXR_VALUE: begin
                    n_skip = r_skip - 32'd1;
                    if (r_skip == 32'd1) begin
                        n_cnt = r_cnt + CntW'(1);
                        if (n_cnt >= CntW'(ATTRIBUTE_LIMIT)) begin
                            n_verdict = ifts_pkg::VERDICT_NO;
                            n_phase   = ifts_pkg::EXR_DONE;
                        end else begin
                            n_phase = ifts_pkg::EXR_NAME;
                            n_prog  = '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_clear)) begin
            r_phase   <= ifts_pkg::EXR_HEADER;
            r_prog    <= '0;
            r_skip    <= '0;
            r_cnt     <= '0;
            r_verdict <= ifts_pkg::VERDICT_PENDING;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_prog    <= n_prog;
            r_skip    <= n_skip;
            r_cnt     <= n_cnt;
            r_verdict <= n_verdict;
        end
    end

    // Verdict including the byte being stepped now, for the final decision.
    assign o_verdict = n_verdict;
endmodule

@@ design/ifts_svg_scan.sv @@
// SVG prologue scanner: BOM, whitespace, PIs, comments, doctypes, root name.
// Depends on ifts_pkg.
module ifts_svg_scan #(
    parameter int SVG_SCAN_BYTES = ifts_pkg::SvgScanBytesDefault,
    parameter int PROLOGUE_LIMIT = ifts_pkg::PrologueLimitDefault
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_step,
    input  logic                     i_clear,
    input  logic [7:0]               i_byte,
    input  logic [ifts_pkg::PosW-1:0] i_pos,
    output logic                     o_is_svg
);
    ifts_pkg::t_svg_phase r_phase, n_phase;
    logic [6:0]  r_ccnt, n_ccnt;
    logic [1:0]  r_q, n_q;
    logic [11:0] r_depth, n_depth;
    logic [31:0] r_tail, n_tail;
    logic [2:0]  r_len, n_len;
    logic [1:0]  r_verdict, n_verdict;
    logic        w_lt, w_sp, w_close;

    always_comb begin
        n_phase   = r_phase;
        n_ccnt    = r_ccnt;
        n_q       = r_q;
        n_depth   = r_depth;
        n_tail    = r_tail;
        n_len     = r_len;
        n_verdict = r_verdict;
        w_sp      = ifts_pkg::is_space(i_byte);
        w_lt      = (i_byte == 8'h3C);
        w_close   = 1'b0;
        if (r_verdict == ifts_pkg::VERDICT_PENDING &&
            i_pos < ifts_pkg::PosW'(SVG_SCAN_BYTES)) begin
            case (r_phase)
                ifts_pkg::SV_BOM0, ifts_pkg::SV_SPACE: begin
                    if (r_phase == ifts_pkg::SV_BOM0 && i_byte == 8'hEF)
                        n_phase = ifts_pkg::SV_BOM1;
                    else if (w_sp) n_phase = ifts_pkg::SV_SPACE;
                    else if (w_lt) n_phase = ifts_pkg::SV_LT;
                    else n_verdict = ifts_pkg::VERDICT_NO;
                end
                ifts_pkg::SV_BOM1: begin
                    if (i_byte == 8'hBB) n_phase = ifts_pkg::SV_BOM2;
                    else n_verdict = ifts_pkg::VERDICT_NO;
                end
                ifts_pkg::SV_BOM2: begin
                    if (i_byte == 8'hBF) n_phase = ifts_pkg::SV_SPACE;
                    else n_verdict = ifts_pkg::VERDICT_NO;
                end
                ifts_pkg::SV_LT: begin
                    if (i_byte == 8'h3F || i_byte == 8'h21) begin
                        if (r_ccnt < 7'(PROLOGUE_LIMIT)) begin
                            if (i_byte == 8'h3F) begin
                                n_phase = ifts_pkg::SV_PI;
                                n_q     = '0;
                            end else begin
                                n_phase = ifts_pkg::SV_BANG;
                            end
                        end else begin
                            n_verdict = ifts_pkg::VERDICT_NO;
                        end
                    end else if (ifts_pkg::is_name_char(i_byte)) begin
                        n_phase = ifts_pkg::SV_NAME;
                        n_tail  = {24'd0, i_byte};
                        n_len   = 3'd1;
                    end else begin
                        n_verdict = ifts_pkg::VERDICT_NO;
                    end
                end
                ifts_pkg::SV_BANG: begin
                    if (i_byte == 8'h2D) n_phase = ifts_pkg::SV_BANGDASH;
                    else if (i_byte == 8'h44) begin
                        n_phase = ifts_pkg::SV_DOCKEY;
                        n_depth = 12'd3;
                    end else n_verdict = ifts_pkg::VERDICT_NO;
                end
                ifts_pkg::SV_BANGDASH: begin
                    if (i_byte == 8'h2D) begin
                        n_phase = ifts_pkg::SV_COMMENT;
                        n_q     = '0;
                    end else n_verdict = ifts_pkg::VERDICT_NO;
                end
                ifts_pkg::SV_DOCKEY: begin
                    if (r_depth < 12'd9 && i_byte == ifts_pkg::doctype_char(r_depth[3:0])) begin
                        n_depth = r_depth + 12'd1;
                        if (r_depth == 12'd8) begin
                            n_phase = ifts_pkg::SV_DOCTYPE;
                            n_depth = '0;
                            n_q     = '0;
                        end
                    end else n_verdict = ifts_pkg::VERDICT_NO;
                end
                ifts_pkg::SV_PI: begin
                    if (r_q != 2'd0 && i_byte == 8'h3E) w_close = 1'b1;
                    else n_q = (i_byte == 8'h3F) ? 2'd1 : 2'd0;
                end
                ifts_pkg::SV_COMMENT: begin
                    if (i_byte == 8'h3E && r_q >= 2'd2) w_close = 1'b1;
                    else if (i_byte == 8'h2D) n_q = (r_q < 2'd2) ? r_q + 2'd1 : 2'd2;
                    else n_q = '0;
                end
                ifts_pkg::SV_DOCTYPE: begin
                    if (r_q != 2'd0) begin
                        if ((r_q == 2'd1 && i_byte == 8'h27) ||
                            (r_q == 2'd2 && i_byte == 8'h22)) n_q = '0;
                    end else if (i_byte == 8'h27) n_q = 2'd1;
                    else if (i_byte == 8'h22) n_q = 2'd2;
                    else if (i_byte == 8'h5B) begin
                        if (r_depth < 12'd4095) n_depth = r_depth + 12'd1;
                    end else if (i_byte == 8'h5D) begin
                        if (r_depth != 12'd0) n_depth = r_depth - 12'd1;
                    end else if (i_byte == 8'h3E && r_depth == 12'd0) w_close = 1'b1;
                end
                ifts_pkg::SV_NAME: begin
                    if (ifts_pkg::is_name_char(i_byte)) begin
                        n_tail = {r_tail[23:0], i_byte};
                        if (r_len < 3'd5) n_len = r_len + 3'd1;
                    end else begin
                        n_verdict = ifts_pkg::name_is_svg(r_tail, r_len) ?
                                    ifts_pkg::VERDICT_YES : ifts_pkg::VERDICT_NO;
                    end
                end
                default: n_verdict = ifts_pkg::VERDICT_NO;
            endcase
            if (w_close) begin
                if (r_ccnt < 7'd127) n_ccnt = r_ccnt + 7'd1;
                n_phase = ifts_pkg::SV_SPACE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_clear)) begin
            r_phase   <= ifts_pkg::SV_BOM0;
            r_ccnt    <= '0;
            r_q       <= '0;
            r_depth   <= '0;
            r_len     <= '0;
            r_verdict <= ifts_pkg::VERDICT_PENDING;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_ccnt    <= n_ccnt;
            r_q       <= n_q;
            r_depth   <= n_depth;
            r_len     <= n_len;
            r_verdict <= n_verdict;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) r_tail <= n_tail;
    end

    // Final judgement: a pending scan counts only if it stands in a root name.
    assign o_is_svg = (n_verdict == ifts_pkg::VERDICT_YES) ||
                      (n_verdict == ifts_pkg::VERDICT_PENDING &&
                       n_phase == ifts_pkg::SV_NAME && ifts_pkg::name_is_svg(n_tail, n_len));
endmodule

@@ design/image_file_type_sniffer_unit.sv @@
// Top level of the image file type sniffer.
// Depends on ifts_pkg, ifts_exr_walk and ifts_svg_scan.
//
// Feed a file one byte per transfer, from offset zero, and mark its final byte
// with last_byte. Every byte is consumed in the cycle it is accepted, so the
// block takes one byte per clock, bar a held-off last byte; the rate is set by the
// single registered pass through the EXR walker and SVG scanner, which update once
// per byte. On the transfer that carries the last byte, the verdict (file_kind,
// signature_id) is computed from the head bytes, the last eighteen bytes and both
// scanners, and appears in the output register on the next cycle; the scanning
// state then returns to its reset value so the following byte starts a new file.
// Bytes that are not last produce no result. The output register holds one result;
// while it waits for the sink, further non-last bytes are still taken, and a second
// last byte is held off only until the register drains. No clearing pass after reset.
module image_file_type_sniffer_unit #(
    parameter int SVG_SCAN_BYTES  = ifts_pkg::SvgScanBytesDefault,
    parameter int PROLOGUE_LIMIT  = ifts_pkg::PrologueLimitDefault,
    parameter int ATTRIBUTE_LIMIT = ifts_pkg::AttributeLimitDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  ifts_pkg::t_in_item i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output ifts_pkg::t_out_item o_item
);
    logic [ifts_pkg::PosW-1:0] r_pos;
    logic [7:0] r_head [ifts_pkg::HeadN];
    logic [7:0] r_tail [ifts_pkg::TailN];
    logic [7:0] w_h [ifts_pkg::HeadN];
    logic [7:0] w_t [ifts_pkg::TailN];
    logic [ifts_pkg::PosW-1:0] w_cnt;
    logic       w_step, w_last;
    logic [1:0] w_exr_verdict;
    logic       w_svg;
    logic       w_tga;
    logic       r_valid;
    ifts_pkg::t_out_item r_item, n_item;

    // Accept plain bytes always; a last byte needs room in the output register.
    assign o_ready = !r_valid || i_ready || !i_item.last_byte;
    assign w_step  = i_valid && o_ready;
    assign w_last  = i_item.last_byte;

    ifts_exr_walk #(.ATTRIBUTE_LIMIT(ATTRIBUTE_LIMIT)) u_exr (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(w_step), .i_clear(w_last),
        .i_byte(i_item.data_byte), .i_pos(r_pos), .o_verdict(w_exr_verdict)
    );

    ifts_svg_scan #(.SVG_SCAN_BYTES(SVG_SCAN_BYTES), .PROLOGUE_LIMIT(PROLOGUE_LIMIT)) u_svg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(w_step), .i_clear(w_last),
        .i_byte(i_item.data_byte), .i_pos(r_pos), .o_is_svg(w_svg)
    );

    // Head and tail views that include the byte arriving now.
    assign w_cnt = (r_pos < ifts_pkg::PosMax) ? r_pos + 1'b1 : ifts_pkg::PosMax;
    always_comb begin
        for (int k = 0; k < ifts_pkg::HeadN; k++)
            w_h[k] = (r_pos == ifts_pkg::PosW'(k)) ? i_item.data_byte : r_head[k];
        for (int k = 0; k < ifts_pkg::TailN - 1; k++) w_t[k] = r_tail[k+1];
        w_t[ifts_pkg::TailN-1] = i_item.data_byte;
        w_tga = 1'b1;
        for (int k = 0; k < ifts_pkg::TailN; k++)
            if (w_t[k] != ifts_pkg::tga_foot_char(k)) w_tga = 1'b0;
    end

    // Priority classification of the finished file.
    always_comb begin
        n_item.file_kind    = ifts_pkg::KIND_RASTER;
        n_item.signature_id = ifts_pkg::SIG_NONE;
        if (w_cnt >= 4 && {w_h[0], w_h[1], w_h[2], w_h[3]} == 32'h762F_3101) begin
            n_item.signature_id = ifts_pkg::SIG_EXR;
            if (w_exr_verdict == ifts_pkg::VERDICT_YES) n_item.file_kind = ifts_pkg::KIND_PAINT;
        end else if (w_cnt >= 8 && {w_h[0], w_h[1], w_h[2], w_h[3], w_h[4], w_h[5], w_h[6],
                     w_h[7]} == 64'h8950_4E47_0D0A_1A0A)
            n_item.signature_id = ifts_pkg::SIG_PNG;
        else if (w_cnt >= 4 && {w_h[0], w_h[1], w_h[2], w_h[3]} == "8BPS")
            n_item.signature_id = ifts_pkg::SIG_PSD;
        else if ((w_cnt >= 10 && {w_h[0], w_h[1], w_h[2], w_h[3], w_h[4], w_h[5], w_h[6],
                  w_h[7], w_h[8], w_h[9]} == "#?RADIANCE") ||
                 (w_cnt >= 6 && {w_h[0], w_h[1], w_h[2], w_h[3], w_h[4], w_h[5]} == "#?RGBE"))
            n_item.signature_id = ifts_pkg::SIG_HDR;
        else if (w_cnt >= 4 && ({w_h[0], w_h[1], w_h[2], w_h[3]} == "SDPX" ||
                                {w_h[0], w_h[1], w_h[2], w_h[3]} == "XPDS"))
            n_item.signature_id = ifts_pkg::SIG_DPX;
        else if (w_cnt >= 4 && {w_h[0], w_h[1], w_h[2], w_h[3]} == 32'h802A_5FD7)
            n_item.signature_id = ifts_pkg::SIG_CIN;
        else if (w_cnt >= 6 && ({w_h[0], w_h[1], w_h[2], w_h[3], w_h[4], w_h[5]} == "GIF87a" ||
                                {w_h[0], w_h[1], w_h[2], w_h[3], w_h[4], w_h[5]} == "GIF89a"))
            n_item.signature_id = ifts_pkg::SIG_GIF;
        else if (w_cnt >= 12 && {w_h[0], w_h[1], w_h[2], w_h[3]} == "RIFF" &&
                 {w_h[8], w_h[9], w_h[10], w_h[11]} == "WEBP")
            n_item.signature_id = ifts_pkg::SIG_WEBP;
        else if (w_cnt >= 4 && ({w_h[0], w_h[1], w_h[2], w_h[3]} == 32'h4949_2A00 ||
                                {w_h[0], w_h[1], w_h[2], w_h[3]} == 32'h4D4D_002A))
            n_item.signature_id = ifts_pkg::SIG_TIFF;
        else if (w_cnt >= 3 && {w_h[0], w_h[1], w_h[2]} == 24'hFFD8FF)
            n_item.signature_id = ifts_pkg::SIG_JPEG;
        else if (w_cnt >= 2 && {w_h[0], w_h[1]} == "BM")
            n_item.signature_id = ifts_pkg::SIG_BMP;
        else if (w_cnt >= 3 && w_h[0] == "P" && w_h[1] inside {[8'h31:8'h37]} &&
                 ifts_pkg::is_space(w_h[2]))
            n_item.signature_id = ifts_pkg::SIG_PNM;
        else if (w_cnt >= 18 && w_tga)
            n_item.signature_id = ifts_pkg::SIG_TGA;
        else if (w_svg) begin
            n_item.file_kind    = ifts_pkg::KIND_VECTOR;
            n_item.signature_id = ifts_pkg::SIG_SVG;
        end else begin
            n_item.file_kind = ifts_pkg::KIND_UNKNOWN;
        end
    end

    // Advance position and byte history; drop everything after a last byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (w_step) begin
            r_pos <= w_last ? '0 : w_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ifts_pkg::HeadN; k++) r_head[k] <= '0;
            for (int k = 0; k < ifts_pkg::TailN; k++) r_tail[k] <= '0;
        end else if (w_step) begin
            for (int k = 0; k < ifts_pkg::HeadN; k++) r_head[k] <= w_last ? 8'd0 : w_h[k];
            for (int k = 0; k < ifts_pkg::TailN; k++) r_tail[k] <= w_last ? 8'd0 : w_t[k];
        end
    end

    // Output register: load on a last-byte transfer, hold until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_step && w_last) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_last) r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

@@ design/ifts_checker.sv @@
// Port-level checker for the image file type sniffer, bound to the top level.
// Depends on ifts_pkg.
module ifts_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input ifts_pkg::t_in_item  i_item,
    input logic                o_valid,
    input logic                i_ready,
    input ifts_pkg::t_out_item o_item
);
    a_unknown_no_sig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.file_kind == ifts_pkg::KIND_UNKNOWN |->
        o_item.signature_id == ifts_pkg::SIG_NONE)
        else $error("unknown kind with a signature");

    a_result_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_item.last_byte |=> o_valid)
        else $error("no result after last byte");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && o_ready && i_item.last_byte))
        else $error("result without last byte");

    a_plain_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_item.last_byte |-> o_ready)
        else $error("plain byte stalled");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item))
        else $error("result changed while stalled");
endmodule

bind image_file_type_sniffer_unit ifts_checker u_ifts_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .i_item(i_item), .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item)
);
